[rtl/cobp_pkg.sv]
// ----------------------------------------------------------------------------
// cobp_pkg
// Shared widths, types and state codes for the position-ordered character sort.
// ----------------------------------------------------------------------------
`default_nettype none

package cobp_pkg;

  localparam int CODE_W = 8;
  localparam int KEY_W  = 10;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [CODE_W-1:0] code;
  } entry_t;

  typedef struct packed {
    logic ins;
    logic shift;
  } cell_ctl_t;

  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

[rtl/cobp_ifs.sv]
// ----------------------------------------------------------------------------
// cobp_ifs
// Valid/ready channel interfaces for character input and sorted results.
// ----------------------------------------------------------------------------
`default_nettype none

interface cobp_in_if;
  import cobp_pkg::*;

  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] char_code;
  logic [KEY_W-1:0]  char_x;
  logic              last_char;

  modport source (output valid, output char_code, output char_x, output last_char,
                  input ready);
  modport sink   (input valid, input char_code, input char_x, input last_char,
                  output ready);
endinterface

interface cobp_out_if;
  import cobp_pkg::*;

  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] out_code;
  logic              out_last;
  logic              overflow;

  modport source (output valid, output out_code, output out_last, output overflow,
                  input ready);
  modport sink   (input valid, input out_code, input out_last, input overflow,
                  output ready);
endinterface

`default_nettype wire

[rtl/cobp_cell.sv]
// ----------------------------------------------------------------------------
// cobp_cell
// One slot of the insertion chain: holds a key/code pair, shifts up on insert
// and down on emit.
// ----------------------------------------------------------------------------
`default_nettype none

module cobp_cell (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cobp_pkg::cell_ctl_t ctl,
  input  wire cobp_pkg::entry_t   new_entry,
  input  wire logic               prev_valid,
  input  wire logic               prev_gt,
  input  wire cobp_pkg::entry_t   prev_entry,
  input  wire logic               next_valid,
  input  wire cobp_pkg::entry_t   next_entry,
  output logic                    valid,
  output logic                    gt,
  output cobp_pkg::entry_t        entry
);
  import cobp_pkg::*;

  logic   valid_r;
  logic   valid_nxt;
  entry_t entry_r;
  entry_t entry_nxt;

  assign gt    = valid_r && (entry_r.key > new_entry.key);
  assign valid = valid_r;
  assign entry = entry_r;

  always_comb begin
    valid_nxt = valid_r;
    entry_nxt = entry_r;
    if (ctl.ins) begin
      if (prev_gt) begin
        valid_nxt = 1'b1;
        entry_nxt = prev_entry;
      end else if (prev_valid && (gt || !valid_r)) begin
        valid_nxt = 1'b1;
        entry_nxt = new_entry;
      end
    end else if (ctl.shift) begin
      valid_nxt = next_valid;
      entry_nxt = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

`default_nettype wire

[rtl/cobp_ctrl.sv]
// ----------------------------------------------------------------------------
// cobp_ctrl
// Load/emit sequencer and sticky overflow flag for the insertion chain.
// ----------------------------------------------------------------------------
`default_nettype none

module cobp_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic                in_last,
  input  wire logic                full,
  input  wire logic                more,
  input  wire logic                out_free,
  output logic                     in_ready,
  output cobp_pkg::cell_ctl_t      ctl,
  output logic                     dropped
);
  import cobp_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   dropped_r;
  logic   dropped_nxt;

  assign dropped = dropped_r;

  always_comb begin
    state_nxt   = state_r;
    dropped_nxt = dropped_r;
    in_ready    = 1'b0;
    ctl         = '0;
    case (state_r)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.ins = !full;
          if (full) begin
            dropped_nxt = 1'b1;
          end
          if (in_last) begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          ctl.shift = 1'b1;
          if (!more) begin
            state_nxt   = ST_LOAD;
            dropped_nxt = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_LOAD;
      dropped_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      dropped_r <= dropped_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/char_order_by_position_sort_unit.sv]
// ----------------------------------------------------------------------------
// char_order_by_position_sort_unit
// Collects characters into a sorted insertion chain keyed by column and
// streams the codes out in ascending column order, ties in arrival order.
//
//   channel  role    payload                          handshake
//   in_ch    sink    char_code[8] char_x[10] last_char valid/ready
//   out_ch   source  out_code[8] out_last overflow     valid/ready
//
// While loading, the input is always ready and each compare cell checks its
// key against the incoming one in parallel; a character that finds the chain
// full is dropped and flags overflow. After the last character the input is
// held off while the chain shifts one code per cycle into the output register
// whenever the output is free. Reset is synchronous and clears the cell valid
// bits, sequencer and output valid flag. Output stalls hold the chain; the
// input reopens once the final code is in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module char_order_by_position_sort_unit #(
  parameter int MAX_CHARS = 16
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  cobp_in_if.sink     in_ch,
  cobp_out_if.source  out_ch
);
  import cobp_pkg::*;

  cell_ctl_t            ctl;
  entry_t               new_entry;
  logic [MAX_CHARS-1:0] valid_w;
  logic [MAX_CHARS-1:0] gt_w;
  entry_t               entry_w [MAX_CHARS];
  logic [MAX_CHARS-1:0] order_ok;
  logic                 dropped;
  logic                 out_free;

  logic                 out_valid_r;
  logic [CODE_W-1:0]    out_code_r;
  logic                 out_last_r;
  logic                 out_ovf_r;

  assign new_entry.key  = in_ch.char_x;
  assign new_entry.code = in_ch.char_code;
  assign out_free       = !out_valid_r || out_ch.ready;

  cobp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_last  (in_ch.last_char),
    .full     (valid_w[MAX_CHARS-1]),
    .more     (valid_w[1]),
    .out_free (out_free),
    .in_ready (in_ch.ready),
    .ctl      (ctl),
    .dropped  (dropped)
  );

  for (genvar i = 0; i < MAX_CHARS; i++) begin : g_cell
    logic   prev_valid;
    logic   prev_gt;
    entry_t prev_entry;
    logic   next_valid;
    entry_t next_entry;

    if (i == 0) begin : g_head
      assign prev_valid = 1'b1;
      assign prev_gt    = 1'b0;
      assign prev_entry = new_entry;
      assign order_ok[i] = 1'b1;
    end else begin : g_body
      assign prev_valid = valid_w[i-1];
      assign prev_gt    = gt_w[i-1];
      assign prev_entry = entry_w[i-1];
      assign order_ok[i] = !valid_w[i] || (entry_w[i-1].key <= entry_w[i].key);
    end

    if (i == MAX_CHARS - 1) begin : g_tail
      assign next_valid = 1'b0;
      assign next_entry = entry_w[i];
    end else begin : g_mid
      assign next_valid = valid_w[i+1];
      assign next_entry = entry_w[i+1];
    end

    cobp_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .new_entry  (new_entry),
      .prev_valid (prev_valid),
      .prev_gt    (prev_gt),
      .prev_entry (prev_entry),
      .next_valid (next_valid),
      .next_entry (next_entry),
      .valid      (valid_w[i]),
      .gt         (gt_w[i]),
      .entry      (entry_w[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.shift) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      out_code_r <= entry_w[0].code;
      out_last_r <= !valid_w[1];
      out_ovf_r  <= dropped;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_code = out_code_r;
  assign out_ch.out_last = out_last_r;
  assign out_ch.overflow = out_ovf_r;

`ifndef SYNTH
  a_chain_packed: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_w & (valid_w + MAX_CHARS'(1))) == '0)
    else $error("cell chain has a hole");

  a_chain_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    &order_ok)
    else $error("cell chain out of column order");

  a_hold_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.last_char) |=> !in_ch.ready)
    else $error("input open right after last character");

  a_final_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.shift && !valid_w[1]) |=> (valid_w == '0 && out_ch.out_last && !dropped))
    else $error("final result did not empty the chain");
`endif

endmodule

`default_nettype wire
